// ----- hdl/twrtc_pkg.sv -----
package twrtc_pkg;

  // Command codes on the func field
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETUP  = 3'd1;
  localparam logic [2:0] PH_DRIVE  = 3'd2;
  localparam logic [2:0] PH_HIGH   = 3'd3;
  localparam logic [2:0] PH_LOW    = 3'd4;
  localparam logic [2:0] PH_RXLOW  = 3'd5;
  localparam logic [2:0] PH_RXSAMP = 3'd6;
  localparam logic [2:0] PH_FINISH = 3'd7;

  // Setup sub-steps held in bit_count during PH_SETUP
  localparam logic [4:0] SU_SCLK_LOW = 5'd0;
  localparam logic [4:0] SU_CE_LOW   = 5'd1;
  localparam logic [4:0] SU_CE_HIGH  = 5'd2;

  localparam logic [4:0] LAST_BYTE_BIT = 5'd7;
  localparam logic [4:0] WORD_BITS     = 5'd16;
  localparam logic [7:0] ALL_ONES      = 8'hff;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cmd_addr;
    logic [7:0] wr_data;
    logic       io_in;
  } cmd_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
  } res_t;

endpackage

// ----- hdl/three_wire_rtc_serial_master_top.sv -----
// Three-wire serial RTC interface master. Every command transfer is one tick of the
// pin sequencer and yields exactly one result transfer carrying the pin levels
// after that tick, plus busy, a one-tick done pulse and the last received byte.
// A write (func 1) or read (func 2) is taken only while idle; func is ignored
// while a transaction runs. Writes send cmd_addr then wr_data LSB first, three
// ticks per bit; reads send cmd_addr, release io and shift in eight bits, and
// with retry set a received 0xff restarts the read. Throughput is one
// command transfer per clock while cmd_stall is low: the whole tick step is a single
// pass of logic from the state registers to the output buffer, so each result is
// registered from its own command. A two-entry output buffer (result register plus
// skid) lets the block keep taking commands while one finished result waits; cmd_stall
// rises only when both entries are full. Write cfg_wdata with cfg_we only while
// the block is idle.
module three_wire_rtc_serial_master_top
  import twrtc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  // Sequencer state
  logic       retry;
  logic [2:0] phase, phase_next;
  logic [4:0] bit_count, bit_count_next;
  logic [15:0] tx_shift, tx_shift_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic [7:0] saved_addr, saved_addr_next;
  logic       is_read, is_read_next;
  logic       pin_ce, pin_ce_next;
  logic       pin_sclk, pin_sclk_next;
  logic       pin_io, pin_io_next;
  logic       pin_drive, pin_drive_next;
  logic       done;

  // Output buffer
  logic skid_valid;
  res_t skid;
  res_t res_new;
  logic accept, take;

  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !skid_valid;
  assign take      = res_valid && !res_stall;

  // One tick of the pin sequence
  always_comb begin
    logic       rd_start;
    logic [4:0] bc_inc;
    phase_next      = phase;
    bit_count_next  = bit_count;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    saved_addr_next = saved_addr;
    is_read_next    = is_read;
    pin_ce_next     = pin_ce;
    pin_sclk_next   = pin_sclk;
    pin_io_next     = pin_io;
    pin_drive_next  = pin_drive;
    done            = 1'b0;
    rd_start        = (cmd.func == FUNC_READ);
    bc_inc          = bit_count + 5'd1;

    case (phase)
      PH_IDLE: begin
        if (cmd.func == FUNC_WRITE || cmd.func == FUNC_READ) begin
          // First setup step happens on the start tick itself
          is_read_next    = rd_start;
          saved_addr_next = cmd.cmd_addr;
          tx_shift_next   = rd_start ? {8'h00, cmd.cmd_addr} : {cmd.wr_data, cmd.cmd_addr};
          pin_sclk_next   = 1'b0;
          bit_count_next  = SU_CE_LOW;
          phase_next      = PH_SETUP;
        end
      end
      PH_SETUP: begin
        case (bit_count)
          SU_SCLK_LOW: begin
            pin_sclk_next  = 1'b0;
            bit_count_next = SU_CE_LOW;
          end
          SU_CE_LOW: begin
            pin_ce_next    = 1'b0;
            bit_count_next = SU_CE_HIGH;
          end
          SU_CE_HIGH: begin
            pin_ce_next = 1'b1;
            if (is_read) begin
              bit_count_next = 5'd0;
              phase_next     = PH_DRIVE;
            end else begin
              bit_count_next = 5'd3;
            end
          end
          default: begin
            // Write only: start io low before the first bit
            pin_io_next    = 1'b0;
            pin_drive_next = 1'b1;
            bit_count_next = 5'd0;
            phase_next     = PH_DRIVE;
          end
        endcase
      end
      PH_DRIVE: begin
        pin_io_next    = tx_shift[0];
        pin_drive_next = 1'b1;
        phase_next     = PH_HIGH;
      end
      PH_HIGH: begin
        pin_sclk_next = 1'b1;
        phase_next    = PH_LOW;
      end
      PH_LOW: begin
        if (is_read && bit_count >= LAST_BYTE_BIT) begin
          // Leave sclk high and hand the data pin to the slave
          pin_drive_next = 1'b0;
          pin_io_next    = 1'b0;
          bit_count_next = 5'd0;
          phase_next     = PH_RXLOW;
        end else begin
          pin_sclk_next  = 1'b0;
          tx_shift_next  = {1'b0, tx_shift[15:1]};
          bit_count_next = bc_inc;
          phase_next     = (!is_read && bc_inc >= WORD_BITS) ? PH_FINISH : PH_DRIVE;
        end
      end
      PH_RXLOW: begin
        pin_sclk_next = 1'b0;
        phase_next    = PH_RXSAMP;
      end
      PH_RXSAMP: begin
        rx_shift_next = {cmd.io_in, rx_shift[7:1]};
        if (bit_count >= LAST_BYTE_BIT) begin
          phase_next = PH_FINISH;
        end else begin
          pin_sclk_next  = 1'b1;
          bit_count_next = bc_inc;
          phase_next     = PH_RXLOW;
        end
      end
      default: begin
        pin_ce_next    = 1'b0;
        bit_count_next = 5'd0;
        if (is_read && retry && rx_shift == ALL_ONES) begin
          tx_shift_next = {8'h00, saved_addr};
          phase_next    = PH_SETUP;
        end else begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res_new.chip_enable  = pin_ce_next;
    res_new.serial_clock = pin_sclk_next;
    res_new.io_out       = pin_drive_next & pin_io_next;
    res_new.io_drive     = pin_drive_next;
    res_new.busy_res     = (phase_next != PH_IDLE);
    res_new.done_res     = done;
    res_new.rd_data      = rx_shift_next;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      retry <= 1'b1;
    end else if (cfg_we) begin
      retry <= cfg_wdata;
    end
  end

  // Advance the sequencer once per accepted command transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 5'd0;
      tx_shift   <= 16'h0000;
      rx_shift   <= 8'h00;
      saved_addr <= 8'h00;
      is_read    <= 1'b0;
      pin_ce     <= 1'b0;
      pin_sclk   <= 1'b0;
      pin_io     <= 1'b0;
      pin_drive  <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tx_shift   <= tx_shift_next;
      rx_shift   <= rx_shift_next;
      saved_addr <= saved_addr_next;
      is_read    <= is_read_next;
      pin_ce     <= pin_ce_next;
      pin_sclk   <= pin_sclk_next;
      pin_io     <= pin_io_next;
      pin_drive  <= pin_drive_next;
    end
  end

  // Output buffer control: result register first, skid when it is held
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!res_valid || take) begin
        res <= res_new;
      end else begin
        skid <= res_new;
      end
    end else if (take && skid_valid) begin
      res <= skid;
    end
  end

  // Skid entry is only ever filled behind a held result
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry valid without a result in the output register");

  // A transaction cannot report done and still be busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.done_res) |-> !res.busy_res)
    else $error("done pulse while still busy");

  // Idle is only entered with the bit counter cleared
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (bit_count == 5'd0))
    else $error("idle with nonzero bit count");

  // A held result does not change while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule
